// ----- hdl/qdi_pkg.sv -----
// ----------------------------------------------------------------------------
// qdi_pkg
// Shared types, constants and the phase transition table for the
// quadrature detent index unit.
// ----------------------------------------------------------------------------
package qdi_pkg;

    localparam int COUNT_W = 12;
    localparam int INDEX_W = 8;

    localparam logic [1:0]         REST_STATE      = 2'd3;
    localparam logic [INDEX_W-1:0] TOP_INDEX_RESET = 8'd15;
    localparam logic [COUNT_W-1:0] MINUS_ONE_DETENT = 12'hFFC;

    typedef struct packed {
        logic phase_a;
        logic phase_b;
        logic switch_pressed;
    } sample_t;

    typedef struct packed {
        logic [1:0]         phase;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] pub_index;
        logic               select;
    } state_t;

    // signed step for a move from one phase state to another
    function automatic logic signed [1:0] step_delta(input logic [1:0] from_st,
                                                     input logic [1:0] to_st);
        logic signed [1:0] d;
        d = 2'sd0;
        unique case ({from_st, to_st})
            4'b00_01: d = -2'sd1;
            4'b00_10: d =  2'sd1;
            4'b01_00: d =  2'sd1;
            4'b01_11: d = -2'sd1;
            4'b10_00: d = -2'sd1;
            4'b10_11: d =  2'sd1;
            4'b11_01: d =  2'sd1;
            4'b11_10: d = -2'sd1;
            default:  d =  2'sd0;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/qdi_input_stage.sv -----
// ----------------------------------------------------------------------------
// qdi_input_stage
// Input register for one phase sample request, with valid and stall.
// ----------------------------------------------------------------------------
module qdi_input_stage
    import qdi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  sample_t sample_in,
    input  logic    advance,
    output logic    sample_valid,
    output sample_t sample_out
);

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;
    logic    take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= sample_in;
        end
    end

    assign sample_valid = valid_reg;
    assign sample_out   = sample_reg;

endmodule

// ----- hdl/qdi_update.sv -----
// ----------------------------------------------------------------------------
// qdi_update
// Next-state logic: step count update, detent index with wrap rules and
// select flag handling for one sample.
// ----------------------------------------------------------------------------
module qdi_update
    import qdi_pkg::*;
(
    input  sample_t            sample,
    input  state_t             state_cur,
    input  logic [INDEX_W-1:0] top_index,
    output state_t             state_next,
    output logic               changed
);

    logic [1:0]         now_phase;
    logic [COUNT_W-1:0] cnt;
    logic [INDEX_W-1:0] idx;
    logic signed [1:0]  delta;

    always_comb
    begin
        now_phase  = {sample.phase_a, sample.phase_b};
        delta      = step_delta(state_cur.phase, now_phase);
        state_next = state_cur;
        changed    = 1'b0;
        cnt        = state_cur.count + {{(COUNT_W-2){delta[1]}}, delta};
        idx        = cnt[INDEX_W+1:2];

        if (now_phase != state_cur.phase)
        begin
            state_next.count = cnt;
            if (now_phase == REST_STATE)
            begin
                // one detent below zero wraps to the top
                if (cnt == MINUS_ONE_DETENT)
                begin
                    idx              = top_index;
                    state_next.count = {{(COUNT_W-INDEX_W-2){1'b0}}, top_index, 2'b00};
                end
                if (idx > top_index)
                begin
                    idx              = '0;
                    state_next.count = '0;
                end
                if (idx != state_cur.pub_index)
                begin
                    state_next.pub_index = idx;
                    state_next.select    = 1'b0;
                    changed              = 1'b1;
                end
            end
            state_next.phase = now_phase;
        end

        if (sample.switch_pressed)
        begin
            state_next.select = 1'b1;
        end
    end

endmodule

// ----- hdl/quadrature_detent_index_unit.sv -----
// ----------------------------------------------------------------------------
// quadrature_detent_index_unit
// Rotary encoder decoder: phase samples and switch in, wrapping detent
// index with change and select flags out.
// ----------------------------------------------------------------------------
// a request passes the input register, then the output register, before its result is valid
// throughput: one request per cycle while the output is not stalled by out_stall
// reset: index 0, count 0, phase state at rest, top index 15, no result held
module quadrature_detent_index_unit
    import qdi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               top_index_we,
    input  logic [INDEX_W-1:0] top_index_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               phase_a,
    input  logic               phase_b,
    input  logic               switch_pressed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] station_index,
    output logic               index_changed,
    output logic               select_flag
);

    sample_t            sample_in;
    sample_t            sample_q;
    logic               sample_valid;
    logic               advance;
    state_t             state_reg;
    state_t             state_next;
    logic               changed;
    logic [INDEX_W-1:0] top_index_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] index_reg;
    logic               changed_reg;
    logic               select_reg;

    assign sample_in = '{phase_a: phase_a, phase_b: phase_b,
                         switch_pressed: switch_pressed};

    assign advance        = sample_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    qdi_input_stage u_input (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .advance      (advance),
        .sample_valid (sample_valid),
        .sample_out   (sample_q)
    );

    qdi_update u_update (
        .sample     (sample_q),
        .state_cur  (state_reg),
        .top_index  (top_index_reg),
        .state_next (state_next),
        .changed    (changed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: REST_STATE, count: '0, pub_index: '0, select: 1'b0};
            top_index_reg <= TOP_INDEX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (top_index_we)
            begin
                top_index_reg <= top_index_wdata;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg   <= state_next.pub_index;
            changed_reg <= changed;
            select_reg  <= state_next.select;
        end
    end

    assign out_valid     = out_valid_reg;
    assign station_index = index_reg;
    assign index_changed = changed_reg;
    assign select_flag   = select_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrature detent index unit. A short table of
// hand-picked phase and switch requests is followed by a long rotation that
// wraps the detent index, then random rotation with noise under several top
// index settings and with random gaps on both channels. Results are checked
// against a cycle-free model of the decoder, or typed rows' expected values.
// ----------------------------------------------------------------------------
module tb_top;
    import qdi_pkg::*;

    localparam int  N_SEGMENTS  = 6;
    localparam int  SEG_ITEMS   = 72;
    localparam int  WRAP_UP     = 1032;
    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_WAIT  = 4;
    localparam int  N_DIRECTED  = 26;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               chg;
        logic               sel;
    } detent_t;

    typedef struct packed {
        logic    a;
        logic    b;
        logic    sw;
        logic    typed;
        detent_t res;
    } row_t;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               top_index_we    = 1'b0;
    logic [INDEX_W-1:0] top_index_wdata = '0;
    logic               in_valid        = 1'b0;
    logic               in_stall;
    logic               phase_a         = 1'b1;
    logic               phase_b         = 1'b1;
    logic               switch_pressed  = 1'b0;
    logic               out_valid;
    logic               out_stall       = 1'b0;
    logic [INDEX_W-1:0] station_index;
    logic               index_changed;
    logic               select_flag;

    logic [1:0]                pd_phase  = REST_STATE;
    logic signed [COUNT_W-1:0] pd_count  = '0;
    logic [INDEX_W-1:0]        pd_index  = '0;
    logic                      pd_select = 1'b0;
    logic [INDEX_W-1:0]        pd_max    = TOP_INDEX_RESET;

    detent_t    pending_detents [$];
    int         errors        = 0;
    int         requests_sent = 0;
    int         results_seen  = 0;
    int         changes_seen  = 0;
    int         tx_idle_pct   = 0;
    int         rx_idle_pct   = 0;
    int         hold_left     = 0;
    bit         hold_req      = 1'b0;
    bit         spin_up       = 1'b1;
    logic [1:0] tx_phase      = REST_STATE;

    row_t dir_rows [0:N_DIRECTED-1] = '{
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b1, 1'b1, 1'b1, '{8'd0,  1'b0, 1'b1}},
        '{1'b1, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b1, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd15, 1'b1, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd15, 1'b0, 1'b0}},
        '{1'b0, 1'b1, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b0, 1'b1, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd0,  1'b1, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b1, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b1, 1'b1, 1'b1, '{8'd1,  1'b1, 1'b1}},
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd1,  1'b0, 1'b1}},
        '{1'b1, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b1, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd0,  1'b1, 1'b0}},
        '{1'b1, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b0, 1'b1, 1'b0, 1'b0, '{8'd0,  1'b0, 1'b0}},
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd15, 1'b1, 1'b0}}
    };

    quadrature_detent_index_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .top_index_we    (top_index_we),
        .top_index_wdata (top_index_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .phase_a         (phase_a),
        .phase_b         (phase_b),
        .switch_pressed  (switch_pressed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .station_index   (station_index),
        .index_changed   (index_changed),
        .select_flag     (select_flag)
    );

    always #10 clk = ~clk;

    function automatic int detent_step(input logic [1:0] from_st, input logic [1:0] to_st);
        case ({from_st, to_st})
            4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
            default:                            return 0;
        endcase
    endfunction

    function automatic detent_t predict_detent(input logic a, input logic b, input logic sw);
        logic [1:0]                now;
        logic signed [COUNT_W-1:0] quot;
        logic [INDEX_W-1:0]        idx;
        detent_t                   res;
        now     = {a, b};
        res.chg = 1'b0;
        if (now != pd_phase)
        begin
            pd_count = pd_count + COUNT_W'(detent_step(pd_phase, now));
            if (now == REST_STATE)
            begin
                quot = pd_count >>> 2;
                idx  = quot[INDEX_W-1:0];
                // one detent below zero wraps to the top
                if (pd_count == -4)
                begin
                    idx      = pd_max;
                    pd_count = {2'b00, pd_max, 2'b00};
                end
                if (idx > pd_max)
                begin
                    idx      = '0;
                    pd_count = '0;
                end
                if (idx != pd_index)
                begin
                    pd_index  = idx;
                    pd_select = 1'b0;
                    res.chg   = 1'b1;
                end
            end
            pd_phase = now;
        end
        if (sw)
            pd_select = 1'b1;
        res.idx = pd_index;
        res.sel = pd_select;
        return res;
    endfunction

    function automatic logic [1:0] gray_next(input logic [1:0] s, input bit up);
        case (s)
            2'd0:    return up ? 2'd2 : 2'd1;
            2'd1:    return up ? 2'd0 : 2'd3;
            2'd2:    return up ? 2'd3 : 2'd0;
            default: return up ? 2'd1 : 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] pick_phase(input logic [1:0] cur);
        int roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 10)
            spin_up = ~spin_up;
        if (roll < 70)
            return gray_next(cur, spin_up);
        else if (roll < 82)
            return cur;
        else if (roll < 90)
            return cur ^ 2'b11;
        return 2'($urandom_range(0, 3));
    endfunction

    task automatic send_sample(input logic a, input logic b, input logic sw,
                               input bit typed, input detent_t typed_res);
        detent_t res;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        phase_a        <= a;
        phase_b        <= b;
        switch_pressed <= sw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_detent(a, b, sw);
        if (typed)
            res = typed_res;
        pending_detents.push_back(res);
        requests_sent++;
        tx_phase = {a, b};
    endtask

    task automatic send_random;
        logic [1:0] nxt;
        nxt = pick_phase(tx_phase);
        send_sample(nxt[1], nxt[0], $urandom_range(0, 99) < 12, 1'b0, '0);
    endtask

    task automatic send_turn(input bit up);
        logic [1:0] nxt;
        nxt = gray_next(tx_phase, up);
        send_sample(nxt[1], nxt[0], $urandom_range(0, 99) < 5, 1'b0, '0);
    endtask

    task automatic drain_requests;
        in_valid <= 1'b0;
        wait (pending_detents.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_top_index(input logic [INDEX_W-1:0] value);
        @(posedge clk);
        top_index_we    <= 1'b1;
        top_index_wdata <= value;
        @(posedge clk);
        top_index_we    <= 1'b0;
        pd_max = value;
    endtask

    task automatic report_field(input string name, input int exp, input int act);
        if (exp != act)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
        end
    endtask

    // result monitor and receiver stall
    always @(posedge clk)
    begin
        detent_t exp;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_detents.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual idx %0d chg %0d sel %0d",
                             $time, station_index, index_changed, select_flag);
                end
                else
                begin
                    exp = pending_detents.pop_front();
                    results_seen++;
                    if (index_changed)
                        changes_seen++;
                    report_field("station_index", int'(exp.idx), int'(station_index));
                    report_field("index_changed", int'(exp.chg), int'(index_changed));
                    report_field("select_flag",   int'(exp.sel), int'(select_flag));
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    initial
    begin
        int seg;
        int i;
        int down_steps;
        logic [INDEX_W-1:0] seg_max;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed requests at the reset top index
        for (i = 0; i < N_DIRECTED; i++)
            send_sample(dir_rows[i].a, dir_rows[i].b, dir_rows[i].sw,
                        dir_rows[i].typed, dir_rows[i].res);

        // turn down to one detent below zero, jump to the top, then turn up
        // until the detent index wraps past the top to zero
        drain_requests();
        tx_idle_pct = 25;
        rx_idle_pct = 57;
        write_top_index(8'd255);
        down_steps = int'(pd_count) + 4;
        for (i = 0; i < down_steps; i++)
            send_turn(1'b0);
        for (i = 0; i < WRAP_UP; i++)
            send_turn(1'b1);

        for (seg = 0; seg < N_SEGMENTS; seg++)
        begin
            drain_requests();
            case (seg / 2)
                0:       begin tx_idle_pct = 25; rx_idle_pct = 57; end
                1:       begin tx_idle_pct = 57; rx_idle_pct = 25; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            case (seg)
                0:       seg_max = 8'd0;
                1:       seg_max = 8'd255;
                2:       seg_max = 8'd2;
                3:       seg_max = 8'($urandom_range(0, 255));
                4:       seg_max = 8'd1;
                default: seg_max = 8'd255;
            endcase
            write_top_index(seg_max);
            if (seg == 4)
                hold_req = 1'b1;
            for (i = 0; i < SEG_ITEMS; i++)
                send_random();
        end
        drain_requests();

        $display("covered %0d requests and %0d results (%0d index changes)",
                 requests_sent, results_seen, changes_seen);
        $display("over %0d top index settings, idle and hold-off traffic, count wrap run",
                 N_SEGMENTS + 2);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", pending_detents.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
